FILE: rtl/core/cbk_pkg.sv
// cbk_pkg: shared types and constants for the per-target circuit breaker core.
// Used by every module under rtl/core; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package cbk_pkg;

    // Table size and derived widths
    localparam int NUM_TARGETS = 64;
    localparam int IDX_W       = (NUM_TARGETS > 1) ? $clog2(NUM_TARGETS) : 1;
    localparam int TALLY_W     = $clog2(NUM_TARGETS + 1);
    localparam int OPEN_SAT    = 127;

    // Field widths fixed by the interface
    localparam int MODE_W   = 3;
    localparam int TARGET_W = 6;
    localparam int TIME_W   = 32;
    localparam int RUN_W    = 16;
    localparam int TOTAL_W  = 32;
    localparam int OPEN_W   = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Mode codes on the input port
    localparam logic [MODE_W-1:0] MODE_REQUEST   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SUCCESS   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_FAILURE   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RESET_ONE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_RESET_ALL = 3'd4;
    localparam logic [MODE_W-1:0] MODE_QUERY     = 3'd5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FAILURE_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SUCCESS_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_TIMEOUT  = 2'd2;

    typedef enum logic [1:0] {
        BRK_CLOSED = 2'd0,
        BRK_OPEN   = 2'd1,
        BRK_HALF   = 2'd2
    } t_brk;

    // Internal operation after classification
    typedef enum logic [2:0] {
        OP_REQUEST,
        OP_SUCCESS,
        OP_FAILURE,
        OP_RESET_ONE,
        OP_RESET_ALL,
        OP_QUERY
    } t_op;

    typedef struct packed {
        t_op                 op;
        logic                in_range;
        logic [TARGET_W-1:0] target;
        logic [TIME_W-1:0]   now_ms;
    } t_cmd;

    typedef struct packed {
        logic [RUN_W-1:0]  failure_limit;
        logic [RUN_W-1:0]  success_limit;
        logic [TIME_W-1:0] open_timeout_ms;
    } t_cfg;

    typedef struct packed {
        t_brk               state;
        logic [TIME_W-1:0]  opened_at;
        logic [RUN_W-1:0]   fail_run;
        logic [RUN_W-1:0]   success_run;
        logic [TOTAL_W-1:0] success_total;
        logic [TOTAL_W-1:0] failure_total;
    } t_entry;

    typedef struct packed {
        logic               allowed;
        logic [1:0]         breaker_state;
        logic               tracked;
        logic [RUN_W-1:0]   run_failures;
        logic [RUN_W-1:0]   run_successes;
        logic [TOTAL_W-1:0] all_successes;
        logic [TOTAL_W-1:0] all_failures;
        logic [OPEN_W-1:0]  open_entries;
    } t_result;

endpackage

`default_nettype wire

FILE: rtl/core/cbk_front.sv
// cbk_front: accepts input beats, classifies the mode, and holds them in a
// two-deep command queue for the back end. Depends on cbk_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cbk_front (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_push,
    output logic                                  o_full,
    input  wire logic [cbk_pkg::MODE_W-1:0]       i_mode,
    input  wire logic [cbk_pkg::TARGET_W-1:0]     i_target,
    input  wire logic [cbk_pkg::TIME_W-1:0]       i_now_ms,
    input  wire logic                             i_pop,
    output logic                                  o_empty,
    output cbk_pkg::t_cmd                         o_cmd
);

    cbk_pkg::t_cmd r_q [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_count;
    logic [1:0]    n_count;
    logic          do_push;
    logic          do_pop;
    cbk_pkg::t_cmd cmd_in;

    // Classify the incoming mode; unused codes act as a query
    always_comb begin
        cmd_in.target   = i_target;
        cmd_in.now_ms   = i_now_ms;
        cmd_in.in_range = (32'(i_target) < 32'(cbk_pkg::NUM_TARGETS));
        case (i_mode)
            cbk_pkg::MODE_REQUEST:   cmd_in.op = cbk_pkg::OP_REQUEST;
            cbk_pkg::MODE_SUCCESS:   cmd_in.op = cbk_pkg::OP_SUCCESS;
            cbk_pkg::MODE_FAILURE:   cmd_in.op = cbk_pkg::OP_FAILURE;
            cbk_pkg::MODE_RESET_ONE: cmd_in.op = cbk_pkg::OP_RESET_ONE;
            cbk_pkg::MODE_RESET_ALL: cmd_in.op = cbk_pkg::OP_RESET_ALL;
            default:                 cmd_in.op = cbk_pkg::OP_QUERY;
        endcase
    end

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_q[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 2'd1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 2'd1;
        end
    end

    // Queue pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) r_wr_ptr <= ~r_wr_ptr;
            if (do_pop)  r_rd_ptr <= ~r_rd_ptr;
            r_count <= n_count;
        end
    end

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wr_ptr] <= cmd_in;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/cbk_back.sv
// cbk_back: breaker table engine. Reads one entry, updates it, writes it
// back when changed and emits one result beat per command. Depends on cbk_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cbk_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire cbk_pkg::t_cfg    i_cfg,
    input  wire logic             i_cmd_empty,
    input  wire cbk_pkg::t_cmd    i_cmd,
    output logic                  o_cmd_pop,
    input  wire logic             i_res_full,
    output logic                  o_res_push,
    output cbk_pkg::t_result      o_res
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_fsm;

    t_fsm                              r_fsm;
    cbk_pkg::t_entry                   r_mem [cbk_pkg::NUM_TARGETS];
    cbk_pkg::t_entry                   r_rd;
    cbk_pkg::t_cmd                     r_cmd;
    logic [cbk_pkg::NUM_TARGETS-1:0]   r_valid;
    logic [cbk_pkg::NUM_TARGETS-1:0]   r_stale;
    logic [cbk_pkg::TALLY_W-1:0]       r_tally;
    logic [cbk_pkg::TALLY_W-1:0]       n_tally;

    logic [cbk_pkg::IDX_W-1:0]         rd_idx;
    logic [cbk_pkg::IDX_W-1:0]         idx;
    logic                              hit;
    logic                              n_hit;
    logic                              allow;
    logic                              wr;
    logic                              was_open;
    logic                              is_open;
    logic [cbk_pkg::TIME_W-1:0]        age;
    cbk_pkg::t_entry                   cur;
    cbk_pkg::t_entry                   nxt;

    assign rd_idx     = cbk_pkg::IDX_W'(i_cmd.target);
    assign idx        = cbk_pkg::IDX_W'(r_cmd.target);
    assign o_cmd_pop  = (r_fsm == S_IDLE) && !i_cmd_empty && !i_res_full;
    assign o_res_push = (r_fsm == S_EXEC);

    // Entry view: a stale entry reads as closed with cleared runs
    always_comb begin
        hit = r_cmd.in_range && r_valid[idx];
        cur = r_rd;
        if (r_stale[idx]) begin
            cur.state       = cbk_pkg::BRK_CLOSED;
            cur.fail_run    = '0;
            cur.success_run = '0;
        end
        if (!hit) begin
            cur = '0;
        end
        age = r_cmd.now_ms - cur.opened_at;
    end

    // Breaker update for the current command
    always_comb begin
        nxt   = cur;
        allow = 1'b0;
        n_hit = hit;
        wr    = 1'b0;
        if (r_cmd.in_range) begin
            case (r_cmd.op)
                cbk_pkg::OP_REQUEST: begin
                    n_hit = 1'b1;
                    wr    = 1'b1;
                    if (!hit) begin
                        allow = 1'b1;
                    end else if (cur.state == cbk_pkg::BRK_OPEN) begin
                        if (age >= i_cfg.open_timeout_ms) begin
                            nxt.state       = cbk_pkg::BRK_HALF;
                            nxt.success_run = '0;
                            allow           = 1'b1;
                        end
                    end else begin
                        allow = 1'b1;
                    end
                end
                cbk_pkg::OP_SUCCESS: begin
                    if (hit) begin
                        wr = 1'b1;
                        if (cur.success_total != '1) begin
                            nxt.success_total = cur.success_total + 1'b1;
                        end
                        if (cur.success_run != '1) begin
                            nxt.success_run = cur.success_run + 1'b1;
                        end
                        nxt.fail_run = '0;
                        if (cur.state == cbk_pkg::BRK_HALF &&
                            nxt.success_run >= i_cfg.success_limit) begin
                            nxt.state       = cbk_pkg::BRK_CLOSED;
                            nxt.success_run = '0;
                        end
                    end
                end
                cbk_pkg::OP_FAILURE: begin
                    n_hit = 1'b1;
                    wr    = 1'b1;
                    if (cur.failure_total != '1) begin
                        nxt.failure_total = cur.failure_total + 1'b1;
                    end
                    if (cur.fail_run != '1) begin
                        nxt.fail_run = cur.fail_run + 1'b1;
                    end
                    nxt.success_run = '0;
                    if (cur.state == cbk_pkg::BRK_CLOSED) begin
                        if (nxt.fail_run >= i_cfg.failure_limit) begin
                            nxt.state     = cbk_pkg::BRK_OPEN;
                            nxt.opened_at = r_cmd.now_ms;
                        end
                    end else if (cur.state == cbk_pkg::BRK_HALF) begin
                        nxt.state     = cbk_pkg::BRK_OPEN;
                        nxt.opened_at = r_cmd.now_ms;
                    end
                end
                cbk_pkg::OP_RESET_ONE: begin
                    if (hit) begin
                        wr              = 1'b1;
                        nxt.state       = cbk_pkg::BRK_CLOSED;
                        nxt.fail_run    = '0;
                        nxt.success_run = '0;
                    end
                end
                cbk_pkg::OP_RESET_ALL: begin
                    // named entry reports as closed; the table is marked stale
                    nxt.state       = cbk_pkg::BRK_CLOSED;
                    nxt.fail_run    = '0;
                    nxt.success_run = '0;
                end
                default: ;
            endcase
        end
    end

    // Open-entry count
    always_comb begin
        was_open = hit && (cur.state == cbk_pkg::BRK_OPEN);
        is_open  = n_hit && (nxt.state == cbk_pkg::BRK_OPEN);
        n_tally  = r_tally;
        if (r_cmd.op == cbk_pkg::OP_RESET_ALL) begin
            n_tally = '0;
        end else if (was_open && !is_open && r_tally != '0) begin
            n_tally = r_tally - 1'b1;
        end else if (!was_open && is_open) begin
            n_tally = r_tally + 1'b1;
        end
    end

    // Result beat
    always_comb begin
        o_res.allowed = allow;
        o_res.tracked = n_hit;
        if (n_hit) begin
            o_res.breaker_state = nxt.state;
            o_res.run_failures  = nxt.fail_run;
            o_res.run_successes = nxt.success_run;
            o_res.all_successes = nxt.success_total;
            o_res.all_failures  = nxt.failure_total;
        end else begin
            o_res.breaker_state = cbk_pkg::BRK_CLOSED;
            o_res.run_failures  = '0;
            o_res.run_successes = '0;
            o_res.all_successes = '0;
            o_res.all_failures  = '0;
        end
        if (32'(n_tally) > cbk_pkg::OPEN_SAT) begin
            o_res.open_entries = cbk_pkg::OPEN_W'(cbk_pkg::OPEN_SAT);
        end else begin
            o_res.open_entries = cbk_pkg::OPEN_W'(n_tally);
        end
    end

    // Sequencer, valid and stale marks, open count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm   <= S_IDLE;
            r_valid <= '0;
            r_stale <= '0;
            r_tally <= '0;
        end else begin
            case (r_fsm)
                S_IDLE: begin
                    if (o_cmd_pop) r_fsm <= S_EXEC;
                end
                S_EXEC: begin
                    r_fsm   <= S_IDLE;
                    r_tally <= n_tally;
                    if (r_cmd.op == cbk_pkg::OP_RESET_ALL) begin
                        r_stale <= r_stale | r_valid;
                    end else if (wr) begin
                        r_valid[idx] <= 1'b1;
                        r_stale[idx] <= 1'b0;
                    end
                end
                default: r_fsm <= S_IDLE;
            endcase
        end
    end

    // Command capture and entry table
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
            r_rd  <= r_mem[rd_idx];
        end
        if (r_fsm == S_EXEC && wr) begin
            r_mem[idx] <= nxt;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/cbk_res_fifo.sv
// cbk_res_fifo: two-deep result queue between the engine and the output
// ports. Depends on cbk_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cbk_res_fifo (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire cbk_pkg::t_result  i_data,
    output logic                   o_full,
    input  wire logic              i_pop,
    output logic                   o_empty,
    output cbk_pkg::t_result       o_data
);

    cbk_pkg::t_result r_q [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic [1:0]       n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_q[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 2'd1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 2'd1;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) r_wr_ptr <= ~r_wr_ptr;
            if (do_pop)  r_rd_ptr <= ~r_rd_ptr;
            r_count <= n_count;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/per_target_circuit_breaker_core.sv
// per_target_circuit_breaker_core: top level of the per-target breaker table.
// Depends on cbk_pkg, cbk_front, cbk_back and cbk_res_fifo.
//
//  channel   direction  handshake                  payload
//  input     in         push / full                i_mode, i_target, i_now_ms
//  result    out        empty / pop                o_allowed .. o_open_entries
//  config    in         i_cfg_we (no wait)         i_cfg_index, i_cfg_data
//
// In the table engine each command is read from the entry memory, then
// updated, written back where changed and its result queued, before the next is taken.
// Reset all follows the same steps; it marks every valid entry stale in flops.
// Synchronous active-low reset clears the valid marks, the open count and
// all queues; no clearing pass over the memory is needed.
// Two-deep queues on the input and result sides let either side stall alone.
`timescale 1ns / 1ps
`default_nettype none

module per_target_circuit_breaker_core (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               push,
    output logic                                    full,
    input  wire logic [cbk_pkg::MODE_W-1:0]         i_mode,
    input  wire logic [cbk_pkg::TARGET_W-1:0]       i_target,
    input  wire logic [cbk_pkg::TIME_W-1:0]         i_now_ms,
    output logic                                    empty,
    input  wire logic                               pop,
    output logic                                    o_allowed,
    output logic [1:0]                              o_breaker_state,
    output logic                                    o_tracked,
    output logic [cbk_pkg::RUN_W-1:0]               o_run_failures,
    output logic [cbk_pkg::RUN_W-1:0]               o_run_successes,
    output logic [cbk_pkg::TOTAL_W-1:0]             o_all_successes,
    output logic [cbk_pkg::TOTAL_W-1:0]             o_all_failures,
    output logic [cbk_pkg::OPEN_W-1:0]              o_open_entries,
    input  wire logic                               i_cfg_we,
    input  wire logic [cbk_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [cbk_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    cbk_pkg::t_cfg    r_cfg;
    cbk_pkg::t_cmd    cmd;
    cbk_pkg::t_result res_in;
    cbk_pkg::t_result res_out;
    logic             cmd_empty;
    logic             cmd_pop;
    logic             res_full;
    logic             res_push;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.failure_limit   <= 16'd5;
            r_cfg.success_limit   <= 16'd2;
            r_cfg.open_timeout_ms <= 32'd30000;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                cbk_pkg::CFG_FAILURE_LIMIT:
                    r_cfg.failure_limit <= i_cfg_data[cbk_pkg::RUN_W-1:0];
                cbk_pkg::CFG_SUCCESS_LIMIT:
                    r_cfg.success_limit <= i_cfg_data[cbk_pkg::RUN_W-1:0];
                cbk_pkg::CFG_OPEN_TIMEOUT:
                    r_cfg.open_timeout_ms <= i_cfg_data[cbk_pkg::TIME_W-1:0];
                default: ;
            endcase
        end
    end

    // Front end: accept and classify
    cbk_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_full   (full),
        .i_mode   (i_mode),
        .i_target (i_target),
        .i_now_ms (i_now_ms),
        .i_pop    (cmd_pop),
        .o_empty  (cmd_empty),
        .o_cmd    (cmd)
    );

    // Back end: table read-modify-write
    cbk_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_empty (cmd_empty),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    // Result queue
    cbk_res_fifo u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (res_out)
    );

    assign o_allowed       = res_out.allowed;
    assign o_breaker_state = res_out.breaker_state;
    assign o_tracked       = res_out.tracked;
    assign o_run_failures  = res_out.run_failures;
    assign o_run_successes = res_out.run_successes;
    assign o_all_successes = res_out.all_successes;
    assign o_all_failures  = res_out.all_failures;
    assign o_open_entries  = res_out.open_entries;

endmodule

`default_nettype wire
